/* hw/rtl/mbna_pkg.sv */
`timescale 1ns / 1ps

package mbna_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_PIC_WIDTH = 2'd0;
    localparam logic [1:0] CFG_MBAFF     = 2'd1;
    localparam logic [1:0] CFG_FMO_CHECK = 2'd2;

    localparam int CFG_DATA_BITS = 8;

    // Left neighbour relation codes
    localparam logic [2:0] SA_NONE             = 3'd0;
    localparam logic [2:0] SA_EVEN_FRAME_FIELD = 3'd1;
    localparam logic [2:0] SA_ODD_FRAME_FIELD  = 3'd2;
    localparam logic [2:0] SA_EVEN_FIELD_FRAME = 3'd3;
    localparam logic [2:0] SA_ODD_FIELD_FRAME  = 3'd4;
    localparam logic [2:0] SA_EVEN_FIELD_FIELD = 3'd5;
    localparam logic [2:0] SA_ODD_FIELD_FIELD  = 3'd6;

    // Up and up-right neighbour relation codes
    localparam logic [1:0] SU_NONE       = 2'd0;
    localparam logic [1:0] SU_EVEN_FIELD = 2'd1;
    localparam logic [1:0] SU_ODD_FIELD  = 2'd2;

    // Up-left neighbour relation codes
    localparam logic [2:0] SD_NONE             = 3'd0;
    localparam logic [2:0] SD_EVEN_FIELD       = 3'd1;
    localparam logic [2:0] SD_ODD_FIELD        = 3'd2;
    localparam logic [2:0] SD_ODD_FRAME_LFIELD = 3'd5;

    // One flag per neighbour
    typedef struct packed {
        logic left;
        logic up;
        logic upright;
        logic upleft;
    } nbr_flags_t;

    // Relation codes of one result beat
    typedef struct packed {
        logic [2:0] left;
        logic [1:0] up;
        logic [1:0] upright;
        logic [2:0] upleft;
        logic       up_factor;
    } nbr_status_t;

endpackage

/* hw/rtl/mbna_frame_calc.sv */
`timescale 1ns / 1ps

module mbna_frame_calc
    import mbna_pkg::*;
#(
    parameter int ADDR_BITS = 14
)
(
    input  logic [ADDR_BITS-1:0]        mb,
    input  logic [7:0]                  column,
    input  logic [ADDR_BITS-2:0]        first,
    input  logic [7:0]                  width,
    input  logic                        fmo,
    input  nbr_flags_t                  decoded,
    output logic signed [ADDR_BITS:0]   addr_left,
    output logic signed [ADDR_BITS:0]   addr_up,
    output logic signed [ADDR_BITS:0]   addr_upright,
    output logic signed [ADDR_BITS:0]   addr_upleft
);

    localparam int SW = ADDR_BITS + 2;
    localparam logic signed [SW-1:0] ONE = SW'(1);

    logic signed [SW-1:0] mb_s;
    logic signed [SW-1:0] first_s;
    logic signed [SW-1:0] width_s;
    logic signed [SW-1:0] a;
    logic signed [SW-1:0] b;
    logic signed [SW-1:0] c;
    logic signed [SW-1:0] d;
    logic                 col_left_ok;
    logic                 col_right_ok;
    nbr_flags_t           avail;

    // Candidate addresses
    assign mb_s    = $signed({2'b00, mb});
    assign first_s = $signed({3'b000, first});
    assign width_s = $signed({{(SW-8){1'b0}}, width});
    assign a = mb_s - ONE;
    assign b = mb_s - width_s;
    assign c = b + ONE;
    assign d = b - ONE;

    // Row edges: x > 0 and x < w - 1
    assign col_left_ok  = (column != 8'd0);
    assign col_right_ok = (({1'b0, column} + 9'd1) < {1'b0, width});

    // Slice test, optionally gated by decoded flags
    always_comb
    begin
        avail.left    = col_left_ok && (a >= first_s);
        avail.up      = (b >= first_s);
        avail.upright = col_right_ok && (c >= first_s);
        avail.upleft  = col_left_ok && (d >= first_s);
        if (fmo)
        begin
            avail = avail & decoded;
        end
    end

    assign addr_left    = avail.left    ? a[ADDR_BITS:0] : '1;
    assign addr_up      = avail.up      ? b[ADDR_BITS:0] : '1;
    assign addr_upright = avail.upright ? c[ADDR_BITS:0] : '1;
    assign addr_upleft  = avail.upleft  ? d[ADDR_BITS:0] : '1;

endmodule

/* hw/rtl/mbna_mbaff_calc.sv */
`timescale 1ns / 1ps

module mbna_mbaff_calc
    import mbna_pkg::*;
#(
    parameter int ADDR_BITS = 14
)
(
    input  logic [ADDR_BITS-1:0]        mb,
    input  logic [7:0]                  column,
    input  logic [ADDR_BITS-2:0]        first,
    input  logic [7:0]                  width,
    input  logic                        cur_field,
    input  nbr_flags_t                  pair_field,
    output logic signed [ADDR_BITS:0]   addr_left,
    output logic signed [ADDR_BITS:0]   addr_up,
    output logic signed [ADDR_BITS:0]   addr_upright,
    output logic signed [ADDR_BITS:0]   addr_upleft,
    output nbr_status_t                 status
);

    localparam int SW = ADDR_BITS + 2;
    localparam logic signed [SW-1:0] ZERO   = '0;
    localparam logic signed [SW-1:0] ONE    = SW'(1);
    localparam logic signed [SW-1:0] TWO    = SW'(2);
    localparam logic signed [SW-1:0] MINUS1 = '1;

    logic signed [SW-1:0] top_s;
    logic signed [SW-1:0] width2_s;
    logic signed [SW-1:0] start_s;
    logic signed [SW-1:0] a0;
    logic signed [SW-1:0] b0;
    logic signed [SW-1:0] c0;
    logic signed [SW-1:0] d0;
    logic signed [SW-1:0] a;
    logic signed [SW-1:0] b;
    logic signed [SW-1:0] c;
    logic signed [SW-1:0] d;
    logic                 col_left_ok;
    logic                 col_right_ok;
    nbr_flags_t           avail;

    // Pair based candidates: top MB of each neighbouring pair
    assign top_s    = $signed({2'b00, mb[ADDR_BITS-1:1], 1'b0});
    assign width2_s = $signed({{(SW-9){1'b0}}, width, 1'b0});
    assign start_s  = $signed({2'b00, first, 1'b0});
    assign a0 = top_s - TWO;
    assign b0 = top_s - width2_s;
    assign c0 = b0 + TWO;
    assign d0 = b0 - TWO;

    assign col_left_ok  = (column != 8'd0);
    assign col_right_ok = (({1'b0, column} + 9'd1) < {1'b0, width});

    assign avail.left    = col_left_ok && (a0 >= start_s);
    assign avail.up      = (b0 >= ZERO) && (b0 >= start_s);
    assign avail.upright = (c0 >= ZERO) && col_right_ok && (c0 >= start_s);
    assign avail.upleft  = (d0 >= ZERO) && col_left_ok && (d0 >= start_s);

    // Top/bottom selection from the field flags
    always_comb
    begin
        a = avail.left    ? a0 : MINUS1;
        b = avail.up      ? b0 : MINUS1;
        c = avail.upright ? c0 : MINUS1;
        d = avail.upleft  ? d0 : MINUS1;
        status = '0;
        if (!mb[0])
        begin
            if (cur_field)
            begin
                // even field MB
                if (avail.left)
                begin
                    status.left = pair_field.left ? SA_EVEN_FIELD_FIELD
                                                  : SA_EVEN_FIELD_FRAME;
                end
                if (avail.up && !pair_field.up)
                begin
                    b = b + ONE;
                end
                status.up = SU_EVEN_FIELD;
                if (avail.upright && !pair_field.upright)
                begin
                    c = c + ONE;
                    status.up_factor = 1'b1;
                end
                status.upright = SU_EVEN_FIELD;
                if (avail.upleft && !pair_field.upleft)
                begin
                    d = d + ONE;
                end
                status.upleft = SD_EVEN_FIELD;
            end
            else
            begin
                // even frame MB: bottom MB of the pairs above
                if (avail.left && pair_field.left)
                begin
                    status.left = SA_EVEN_FRAME_FIELD;
                end
                if (avail.up)
                begin
                    b = b + ONE;
                end
                if (avail.upright)
                begin
                    c = c + ONE;
                end
                if (avail.upleft)
                begin
                    d = d + ONE;
                end
            end
        end
        else
        begin
            if (cur_field)
            begin
                // odd field MB
                if (avail.left)
                begin
                    if (pair_field.left)
                    begin
                        a = a + ONE;
                        status.left = SA_ODD_FIELD_FIELD;
                    end
                    else
                    begin
                        status.left = SA_ODD_FIELD_FRAME;
                    end
                end
                status.up = SU_ODD_FIELD;
                if (avail.up)
                begin
                    b = b + ONE;
                end
                if (avail.upright)
                begin
                    c = c + ONE;
                    status.upright = SU_ODD_FIELD;
                end
                status.upleft = SD_ODD_FIELD;
                if (avail.upleft)
                begin
                    d = d + ONE;
                end
            end
            else
            begin
                // odd frame MB: up is the top MB of its own pair
                b = top_s;
                c = MINUS1;
                if (avail.left)
                begin
                    if (pair_field.left)
                    begin
                        status.left   = SA_ODD_FRAME_FIELD;
                        d             = a0 + ONE;
                        status.upleft = SD_ODD_FRAME_LFIELD;
                    end
                    else
                    begin
                        a = a0 + ONE;
                        d = a0;
                    end
                end
            end
        end
    end

    assign addr_left    = a[ADDR_BITS:0];
    assign addr_up      = b[ADDR_BITS:0];
    assign addr_upright = c[ADDR_BITS:0];
    assign addr_upleft  = d[ADDR_BITS:0];

endmodule

/* hw/rtl/macroblock_neighbour_availability_core.sv */
`timescale 1ns / 1ps

// Macroblock neighbour availability.
// A descriptor beat is taken at a rising edge with start high and busy low.
// busy is held low: a new descriptor may be presented in every cycle.
// Each beat is captured in an input register, the neighbour addresses and
// relation codes are worked out in one pass of compare/add logic, and the
// result is captured in an output register. done marks the result beat for
// exactly one cycle; start reaches done through the input register and then
// the output register. Throughput is 1 beat per cycle.
// Unavailable neighbours read as address -1. In frame mode the relation
// codes and up_factor are zero.
// The configuration port (cfg_we, cfg_index, cfg_data) writes picture width,
// MBAFF enable and FMO check; write only while no beat is in flight.
// Reset (rst_n low) clears the pipeline and loads width 1, frame mode, no
// FMO check. The receiver cannot stall: each result must be taken when done.

module macroblock_neighbour_availability_core
    import mbna_pkg::*;
#(
    parameter int ADDR_BITS = 14
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    // descriptor beat
    input  logic                      start,
    output logic                      busy,
    input  logic [ADDR_BITS-1:0]      mb_index,
    input  logic [7:0]                mb_column,
    input  logic [ADDR_BITS-2:0]      slice_first_mb,
    input  logic                      cur_field,
    input  logic                      left_pair_field,
    input  logic                      up_pair_field,
    input  logic                      upright_pair_field,
    input  logic                      upleft_pair_field,
    input  logic                      left_decoded,
    input  logic                      up_decoded,
    input  logic                      upright_decoded,
    input  logic                      upleft_decoded,
    // result beat
    output logic                      done,
    output logic signed [ADDR_BITS:0] addr_left,
    output logic signed [ADDR_BITS:0] addr_up,
    output logic signed [ADDR_BITS:0] addr_upright,
    output logic signed [ADDR_BITS:0] addr_upleft,
    output logic [2:0]                status_left,
    output logic [1:0]                status_up,
    output logic [1:0]                status_upright,
    output logic [2:0]                status_upleft,
    output logic                      up_factor
);

    logic [7:0]                  pic_width_reg;
    logic                        mbaff_reg;
    logic                        fmo_reg;

    logic                        in_valid_reg;
    logic [ADDR_BITS-1:0]        mb_reg;
    logic [7:0]                  column_reg;
    logic [ADDR_BITS-2:0]        first_reg;
    logic                        cur_field_reg;
    nbr_flags_t                  pair_field_reg;
    nbr_flags_t                  decoded_reg;

    logic signed [ADDR_BITS:0]   fr_left;
    logic signed [ADDR_BITS:0]   fr_up;
    logic signed [ADDR_BITS:0]   fr_upright;
    logic signed [ADDR_BITS:0]   fr_upleft;
    logic signed [ADDR_BITS:0]   mf_left;
    logic signed [ADDR_BITS:0]   mf_up;
    logic signed [ADDR_BITS:0]   mf_upright;
    logic signed [ADDR_BITS:0]   mf_upleft;
    nbr_status_t                 mf_status;

    logic                        done_reg;
    logic signed [ADDR_BITS:0]   left_reg;
    logic signed [ADDR_BITS:0]   left_next;
    logic signed [ADDR_BITS:0]   up_reg;
    logic signed [ADDR_BITS:0]   up_next;
    logic signed [ADDR_BITS:0]   upright_reg;
    logic signed [ADDR_BITS:0]   upright_next;
    logic signed [ADDR_BITS:0]   upleft_reg;
    logic signed [ADDR_BITS:0]   upleft_next;
    nbr_status_t                 status_reg;
    nbr_status_t                 status_next;

    assign busy = 1'b0;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pic_width_reg <= 8'd1;
            mbaff_reg     <= 1'b0;
            fmo_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PIC_WIDTH: pic_width_reg <= cfg_data[7:0];
                CFG_MBAFF:     mbaff_reg     <= cfg_data[0];
                CFG_FMO_CHECK: fmo_reg       <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            mb_reg         <= mb_index;
            column_reg     <= mb_column;
            first_reg      <= slice_first_mb;
            cur_field_reg  <= cur_field;
            pair_field_reg <= '{left_pair_field, up_pair_field,
                                upright_pair_field, upleft_pair_field};
            decoded_reg    <= '{left_decoded, up_decoded,
                                upright_decoded, upleft_decoded};
        end
    end

    mbna_frame_calc #(
        .ADDR_BITS    (ADDR_BITS)
    ) u_frame (
        .mb           (mb_reg),
        .column       (column_reg),
        .first        (first_reg),
        .width        (pic_width_reg),
        .fmo          (fmo_reg),
        .decoded      (decoded_reg),
        .addr_left    (fr_left),
        .addr_up      (fr_up),
        .addr_upright (fr_upright),
        .addr_upleft  (fr_upleft)
    );

    mbna_mbaff_calc #(
        .ADDR_BITS    (ADDR_BITS)
    ) u_mbaff (
        .mb           (mb_reg),
        .column       (column_reg),
        .first        (first_reg),
        .width        (pic_width_reg),
        .cur_field    (cur_field_reg),
        .pair_field   (pair_field_reg),
        .addr_left    (mf_left),
        .addr_up      (mf_up),
        .addr_upright (mf_upright),
        .addr_upleft  (mf_upleft),
        .status       (mf_status)
    );

    // Mode select
    always_comb
    begin
        if (mbaff_reg)
        begin
            left_next    = mf_left;
            up_next      = mf_up;
            upright_next = mf_upright;
            upleft_next  = mf_upleft;
            status_next  = mf_status;
        end
        else
        begin
            left_next    = fr_left;
            up_next      = fr_up;
            upright_next = fr_upright;
            upleft_next  = fr_upleft;
            status_next  = '0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            left_reg    <= left_next;
            up_reg      <= up_next;
            upright_reg <= upright_next;
            upleft_reg  <= upleft_next;
            status_reg  <= status_next;
        end
    end

    assign done           = done_reg;
    assign addr_left      = left_reg;
    assign addr_up        = up_reg;
    assign addr_upright   = upright_reg;
    assign addr_upleft    = upleft_reg;
    assign status_left    = status_reg.left;
    assign status_up      = status_reg.up;
    assign status_upright = status_reg.upright;
    assign status_upleft  = status_reg.upleft;
    assign up_factor      = status_reg.up_factor;

    // Every captured beat yields exactly one result beat in the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |=> done)
        else $error("captured beat produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_valid_reg))
        else $error("result beat without a captured descriptor");

    // Frame mode carries no relation codes
    a_frame_codes: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !mbaff_reg) |-> (status_reg == '0))
        else $error("relation code set in frame mode");

    // up_factor only on an even field MB, whose up-right code is even field
    a_up_factor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && up_factor) |-> (status_upright == SU_EVEN_FIELD))
        else $error("up_factor without even field up-right code");

endmodule
